// ----- rtl/csmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock set mode controller package
// Command codes, field codes, register indexes, reset values, payload
// structs and calendar helper functions shared by the interfaces and the
// controller.
// ----------------------------------------------------------------------------
package csmc_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned FieldW  = 3;
  localparam int unsigned BlinkW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 14;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 3'd0,
    CMD_FUNC  = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_UP    = 3'd4,
    CMD_DOWN  = 3'd5,
    CMD_LEAVE = 3'd6
  } cmd_e;

  localparam logic [FieldW-1:0] FIELD_YEAR   = 3'd0;
  localparam logic [FieldW-1:0] FIELD_MONTH  = 3'd1;
  localparam logic [FieldW-1:0] FIELD_DAY    = 3'd2;
  localparam logic [FieldW-1:0] FIELD_HOUR   = 3'd3;
  localparam logic [FieldW-1:0] FIELD_MINUTE = 3'd4;
  localparam logic [FieldW-1:0] FIELD_SECOND = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_BLINK_TICKS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_YEAR_LOWEST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_YEAR_HIGHEST = 2'd2;

  localparam logic [BlinkW-1:0] BLINK_TICKS_RST  = 8'd50;
  localparam logic [YearW-1:0]  YEAR_LOWEST_RST  = 14'd2018;
  localparam logic [YearW-1:0]  YEAR_HIGHEST_RST = 14'd2100;

  localparam logic [MonthW-1:0]  MONTH_LAST  = 4'd12;
  localparam logic [HourW-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MinuteW-1:0] MINUTE_LAST = 6'd59;

  // Divisibility by 25 uses the multiplicative inverse of 25 modulo 2^14:
  // y is a multiple of 25 exactly when y * inverse, kept to 14 bits, is at
  // most floor((2^14 - 1) / 25).
  localparam logic [YearW-1:0] INV25     = 14'd7209;
  localparam logic [YearW-1:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [YearW-1:0]   now_year;
    logic [MonthW-1:0]  now_month;
    logic [DayW-1:0]    now_day;
    logic [HourW-1:0]   now_hour;
    logic [MinuteW-1:0] now_minute;
    logic [SecondW-1:0] now_second;
  } item_t;

  typedef struct packed {
    logic               in_set_mode;
    logic [YearW-1:0]   show_year;
    logic [MonthW-1:0]  show_month;
    logic [DayW-1:0]    show_day;
    logic [HourW-1:0]   show_hour;
    logic [MinuteW-1:0] show_minute;
    logic [SecondW-1:0] show_second;
    logic               commit_time;
    logic               refresh_display;
    logic               cursor_on;
    logic [FieldW-1:0]  cursor_field;
    logic               cursor_changed;
  } result_t;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = YearW'(y * INV25);
    div25 = (prod <= DIV25_MAX);
    // Multiple of 100 is a multiple of 4 and 25; of 400, of 16 and 25.
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [YearW-1:0]  y,
                                                input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Cyclic step on a value zero-extended to the year width.
  function automatic logic [YearW-1:0] cyc_step(input logic [YearW-1:0] v,
                                                input logic [YearW-1:0] lo,
                                                input logic [YearW-1:0] hi,
                                                input logic             up);
    logic [YearW-1:0] r;
    if (up) begin
      r = (v >= hi) ? lo : YearW'(v + 1'b1);
    end else begin
      r = (v <= lo) ? hi : YearW'(v - 1'b1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/csmc_ifs.sv -----
// ----------------------------------------------------------------------------
// Clock set mode controller channels
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface csmc_in_if
  import csmc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [YearW-1:0]   now_year;
  logic [MonthW-1:0]  now_month;
  logic [DayW-1:0]    now_day;
  logic [HourW-1:0]   now_hour;
  logic [MinuteW-1:0] now_minute;
  logic [SecondW-1:0] now_second;

  modport source (output valid, command, now_year, now_month, now_day, now_hour,
                  now_minute, now_second, input ready);
  modport sink   (input valid, command, now_year, now_month, now_day, now_hour,
                  now_minute, now_second, output ready);
endinterface

interface csmc_out_if
  import csmc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               in_set_mode;
  logic [YearW-1:0]   show_year;
  logic [MonthW-1:0]  show_month;
  logic [DayW-1:0]    show_day;
  logic [HourW-1:0]   show_hour;
  logic [MinuteW-1:0] show_minute;
  logic [SecondW-1:0] show_second;
  logic               commit_time;
  logic               refresh_display;
  logic               cursor_on;
  logic [FieldW-1:0]  cursor_field;
  logic               cursor_changed;

  modport source (output valid, in_set_mode, show_year, show_month, show_day,
                  show_hour, show_minute, show_second, commit_time,
                  refresh_display, cursor_on, cursor_field, cursor_changed,
                  input ready);
  modport sink   (input valid, in_set_mode, show_year, show_month, show_day,
                  show_hour, show_minute, show_second, commit_time,
                  refresh_display, cursor_on, cursor_field, cursor_changed,
                  output ready);
endinterface

interface csmc_cfg_if
  import csmc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/clock_set_mode_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Clock set mode controller
// Watch time-setting controller: button commands and ticks in, one
// display/commit result out for every command transfer.
// Commands arrive on in_i together with the running clock's time. Each one
// produces exactly one result transfer on out_o, carrying the time to show
// (the edit copy in set mode or on commit, the running time otherwise), the
// commit pulse, redraw flags and the cursor. Registers are written through
// cfg_i (index 0 blink ticks, 1 lowest year, 2 highest year); the user must
// write them only while no command is in flight, which the block does not
// enforce. cfg_i is always ready. A command is captured in an input register;
// when the result register is free or draining, one pass of update logic
// (field step, month length, day clamp) updates the edit state and loads the
// result register, which drives result valid. A new command is taken every
// cycle while the receiver does not stall.
// If the receiver stalls, the result register holds and the input register
// still takes one more command, after which in_i.ready drops.
// Reset clears the mode, selection (seconds), blink state and both handshake
// stages and loads the register reset values; the edit copy needs no reset.
// ----------------------------------------------------------------------------
module clock_set_mode_controller_unit
  import csmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  csmc_in_if.sink    in_i,
  csmc_out_if.source out_o,
  csmc_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [BlinkW-1:0] blink_ticks_q;
  logic [YearW-1:0]  year_lowest_q;
  logic [YearW-1:0]  year_highest_q;

  // Controller state.
  logic              active_q, active_d;
  logic [FieldW-1:0] sel_q, sel_d;
  logic              edited_q, edited_d;
  logic              cursor_q, cursor_d;
  logic [BlinkW-1:0] blink_q, blink_d;

  // Edit copy of the time; loaded on entry to set mode.
  logic [YearW-1:0]   ed_year_q, ed_year_d;
  logic [MonthW-1:0]  ed_month_q, ed_month_d;
  logic [DayW-1:0]    ed_day_q, ed_day_d;
  logic [HourW-1:0]   ed_hour_q, ed_hour_d;
  logic [MinuteW-1:0] ed_minute_q, ed_minute_d;
  logic [SecondW-1:0] ed_second_q, ed_second_d;

  // Handshake stages.
  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q, out_d;

  logic in_accept;
  logic proc;

  // Per-command working values.
  cmd_e              cmd;
  logic              step_up;
  logic              leaving;
  logic              commit;
  logic              refresh;
  logic              cchanged;
  logic              use_edit;
  logic [DayW-1:0]   last_day;
  logic [BlinkW-1:0] blink_inc;

  // The input register is processed whenever the result register is empty or
  // is being drained in this cycle.
  assign proc        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || proc;
  assign in_accept   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cmd       = cmd_e'(in_q.command);
    step_up   = (cmd == CMD_UP);
    leaving   = 1'b0;
    commit    = 1'b0;
    refresh   = 1'b0;
    cchanged  = 1'b0;
    blink_inc = BlinkW'(blink_q + 1'b1);

    active_d    = active_q;
    sel_d       = sel_q;
    edited_d    = edited_q;
    cursor_d    = cursor_q;
    blink_d     = blink_q;
    ed_year_d   = ed_year_q;
    ed_month_d  = ed_month_q;
    ed_day_d    = ed_day_q;
    ed_hour_d   = ed_hour_q;
    ed_minute_d = ed_minute_q;
    ed_second_d = ed_second_q;

    // Year and month settle first, so that one month length serves both the
    // day step and the clamp that follows every edit.
    if (sel_q == FIELD_YEAR) begin
      ed_year_d = cyc_step(ed_year_q, year_lowest_q, year_highest_q, step_up);
    end
    if (sel_q == FIELD_MONTH) begin
      ed_month_d = MonthW'(cyc_step(YearW'(ed_month_q), YearW'(1),
                                    YearW'(MONTH_LAST), step_up));
    end
    last_day = month_len(ed_year_d, ed_month_d);

    if (cmd == CMD_FUNC && !active_q) begin
      // Enter set mode with a copy of the running time, seconds selected.
      ed_year_d   = in_q.now_year;
      ed_month_d  = in_q.now_month;
      ed_day_d    = in_q.now_day;
      ed_hour_d   = in_q.now_hour;
      ed_minute_d = in_q.now_minute;
      ed_second_d = in_q.now_second;
      active_d    = 1'b1;
      sel_d       = FIELD_SECOND;
      edited_d    = 1'b0;
      cursor_d    = 1'b1;
      blink_d     = '0;
      refresh     = 1'b1;
      cchanged    = 1'b1;
    end else if (cmd == CMD_FUNC || cmd == CMD_LEAVE) begin
      leaving = 1'b1;
      refresh = (cmd == CMD_FUNC);
      ed_year_d  = ed_year_q;
      ed_month_d = ed_month_q;
    end else if (active_q) begin
      case (cmd)
        CMD_TICK: begin
          ed_year_d  = ed_year_q;
          ed_month_d = ed_month_q;
          if (blink_inc >= blink_ticks_q) begin
            blink_d  = '0;
            cursor_d = !cursor_q;
            cchanged = 1'b1;
          end else begin
            blink_d = blink_inc;
          end
        end
        CMD_LEFT, CMD_RIGHT: begin
          ed_year_d  = ed_year_q;
          ed_month_d = ed_month_q;
          if (cmd == CMD_RIGHT) begin
            sel_d = (sel_q >= FIELD_SECOND) ? FIELD_YEAR : FieldW'(sel_q + 1'b1);
          end else begin
            sel_d = (sel_q == FIELD_YEAR) ? FIELD_SECOND : FieldW'(sel_q - 1'b1);
          end
          cursor_d = 1'b1;
          blink_d  = '0;
          cchanged = 1'b1;
        end
        CMD_UP, CMD_DOWN: begin
          case (sel_q)
            FIELD_DAY: begin
              ed_day_d = DayW'(cyc_step(YearW'(ed_day_q), YearW'(1),
                                        YearW'(last_day), step_up));
            end
            FIELD_HOUR: begin
              ed_hour_d = HourW'(cyc_step(YearW'(ed_hour_q), '0,
                                          YearW'(HOUR_LAST), step_up));
            end
            FIELD_MINUTE: begin
              ed_minute_d = MinuteW'(cyc_step(YearW'(ed_minute_q), '0,
                                              YearW'(MINUTE_LAST), step_up));
            end
            FIELD_SECOND: begin
              ed_second_d = SecondW'(cyc_step(YearW'(ed_second_q), '0,
                                              YearW'(MINUTE_LAST), step_up));
            end
            default: begin
            end
          endcase
          // Keep the day inside the month after any change.
          if (ed_day_d > last_day) begin
            ed_day_d = last_day;
          end
          if (ed_day_d == '0) begin
            ed_day_d = DayW'(1);
          end
          edited_d = 1'b1;
          cursor_d = 1'b1;
          blink_d  = '0;
          refresh  = 1'b1;
          cchanged = 1'b1;
        end
        default: begin
          ed_year_d  = ed_year_q;
          ed_month_d = ed_month_q;
        end
      endcase
    end else begin
      // Display mode ignores everything but entry and leave.
      ed_year_d  = ed_year_q;
      ed_month_d = ed_month_q;
    end

    if (leaving) begin
      commit   = active_q && edited_q;
      active_d = 1'b0;
      edited_d = 1'b0;
      cursor_d = 1'b0;
      cchanged = 1'b1;
    end

    use_edit              = active_d || commit;
    out_d.in_set_mode     = active_d;
    out_d.show_year       = use_edit ? ed_year_d   : in_q.now_year;
    out_d.show_month      = use_edit ? ed_month_d  : in_q.now_month;
    out_d.show_day        = use_edit ? ed_day_d    : in_q.now_day;
    out_d.show_hour       = use_edit ? ed_hour_d   : in_q.now_hour;
    out_d.show_minute     = use_edit ? ed_minute_d : in_q.now_minute;
    out_d.show_second     = use_edit ? ed_second_d : in_q.now_second;
    out_d.commit_time     = commit;
    out_d.refresh_display = refresh;
    out_d.cursor_on       = active_d && cursor_d;
    out_d.cursor_field    = sel_d;
    out_d.cursor_changed  = cchanged;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ticks_q  <= BLINK_TICKS_RST;
      year_lowest_q  <= YEAR_LOWEST_RST;
      year_highest_q <= YEAR_HIGHEST_RST;
      active_q       <= 1'b0;
      sel_q          <= FIELD_SECOND;
      edited_q       <= 1'b0;
      cursor_q       <= 1'b0;
      blink_q        <= '0;
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_BLINK_TICKS:  blink_ticks_q  <= cfg_i.data[BlinkW-1:0];
          CFG_YEAR_LOWEST:  year_lowest_q  <= cfg_i.data[YearW-1:0];
          CFG_YEAR_HIGHEST: year_highest_q <= cfg_i.data[YearW-1:0];
          default: begin
          end
        endcase
      end
      if (proc) begin
        active_q <= active_d;
        sel_q    <= sel_d;
        edited_q <= edited_d;
        cursor_q <= cursor_d;
        blink_q  <= blink_d;
      end
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.command    <= in_i.command;
      in_q.now_year   <= in_i.now_year;
      in_q.now_month  <= in_i.now_month;
      in_q.now_day    <= in_i.now_day;
      in_q.now_hour   <= in_i.now_hour;
      in_q.now_minute <= in_i.now_minute;
      in_q.now_second <= in_i.now_second;
    end
    if (proc) begin
      ed_year_q   <= ed_year_d;
      ed_month_q  <= ed_month_d;
      ed_day_q    <= ed_day_d;
      ed_hour_q   <= ed_hour_d;
      ed_minute_q <= ed_minute_d;
      ed_second_q <= ed_second_d;
      out_q       <= out_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.in_set_mode     = out_q.in_set_mode;
  assign out_o.show_year       = out_q.show_year;
  assign out_o.show_month      = out_q.show_month;
  assign out_o.show_day        = out_q.show_day;
  assign out_o.show_hour       = out_q.show_hour;
  assign out_o.show_minute     = out_q.show_minute;
  assign out_o.show_second     = out_q.show_second;
  assign out_o.commit_time     = out_q.commit_time;
  assign out_o.refresh_display = out_q.refresh_display;
  assign out_o.cursor_on       = out_q.cursor_on;
  assign out_o.cursor_field    = out_q.cursor_field;
  assign out_o.cursor_changed  = out_q.cursor_changed;

  // A commit only happens on the way out of set mode.
  a_commit_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.commit_time |-> !out_q.in_set_mode)
    else $error("commit pulse reported while still in set mode");

  // The cursor is only ever shown in set mode.
  a_cursor_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.cursor_on |-> out_q.in_set_mode)
    else $error("cursor shown outside set mode");

  // Entering set mode selects seconds, shows the cursor and restarts blink.
  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (in_q.command == CMD_FUNC) && !active_q
    |=> active_q && (sel_q == FIELD_SECOND) && cursor_q && (blink_q == '0)
        && !edited_q)
    else $error("set mode entry left wrong state");

  // Every processed command yields a pending result in the next cycle.
  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q)
    else $error("processed command produced no result");

endmodule
